// ----- rtl/core/nrt_pkg.sv -----
// ----------------------------------------------------------------------------
// nrt_pkg
// Types and codes shared by the node registry table: opcodes, status codes,
// the classified command, the per-node link record and the result record.
// ----------------------------------------------------------------------------
package nrt_pkg;

    typedef enum logic [2:0] {
        OP_SET_ID   = 3'd0,
        OP_LOAD     = 3'd1,
        OP_OBSERVE  = 3'd2,
        OP_TAKE_SEQ = 3'd3,
        OP_ADOPT    = 3'd4,
        OP_NOTE_VER = 3'd5,
        OP_MISSED   = 3'd6,
        OP_QUERY    = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NEW_CTX = 2'd1;
    localparam logic [1:0] ST_UNREG   = 2'd2;

    localparam logic [15:0] SEQ_START = 16'd1;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic               found;
        logic [7:0]         version;
        logic [15:0]        ctx;
        logic signed [15:0] rssi;
        logic signed [7:0]  snr;
        logic [31:0]        time_ms;
    } t_cmd;

    typedef struct packed {
        logic               heard;
        logic [31:0]        last_seen;
        logic [31:0]        frames;
        logic [7:0]         proto;
        logic [7:0]         bad_ver;
        logic signed [15:0] rssi;
        logic signed [7:0]  snr;
        logic [15:0]        missed;
        logic [15:0]        ctx;
        logic [15:0]        seq;
    } t_link;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        seq;
        logic [15:0]        ctx;
        logic               heard;
        logic [31:0]        last_seen;
        logic [31:0]        frames;
        logic [7:0]         proto;
        logic [7:0]         bad_ver;
        logic signed [15:0] rssi;
        logic signed [7:0]  snr;
        logic [15:0]        missed;
    } t_result;

endpackage

// ----- rtl/core/node_registry_table.sv -----
// ----------------------------------------------------------------------------
// node_registry_table
// Registry of radio nodes: slot ids, a load command, and per-node link state
// updated or reported by each event on the lowest matching slot.
//
//   channel   direction  handshake           fields
//   input     in         push / full         opcode slot node_id version
//                                            context_id rssi snr time_ms
//   result    out        empty / pop         status seq_out ctx_out heard_out
//                                            last_seen_out frames_out proto_out
//                                            bad_version_out rssi_out snr_out
//                                            missed_out
//
// In the back part, an idle state reads the node's link record from memory
// and an exec state updates it and writes it back; in this read-modify-write
// loop the back part takes no new item until the last one is written back.
// The id match is registered in the front, and a two-entry queue separates
// front and back. Reset clears ids, the loaded flag and per-entry valid bits
// at once; load clears all the valid bits together. A stalled result holds the
// back part, which then fills the queue and raises full.
// ----------------------------------------------------------------------------
module node_registry_table #(
    parameter int NODES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_opcode,
    input  logic [3:0]         i_slot,
    input  logic [7:0]         i_node_id,
    input  logic [7:0]         i_version,
    input  logic [15:0]        i_context_id,
    input  logic signed [15:0] i_rssi,
    input  logic signed [7:0]  i_snr,
    input  logic [31:0]        i_time_ms,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_status,
    output logic [15:0]        o_seq_out,
    output logic [15:0]        o_ctx_out,
    output logic               o_heard_out,
    output logic [31:0]        o_last_seen_out,
    output logic [31:0]        o_frames_out,
    output logic [7:0]         o_proto_out,
    output logic [7:0]         o_bad_version_out,
    output logic signed [15:0] o_rssi_out,
    output logic signed [7:0]  o_snr_out,
    output logic [15:0]        o_missed_out
);
    import nrt_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int QW = $bits(t_cmd) + IW;

    t_cmd          f_cmd;
    logic [IW-1:0] f_idx;
    logic          f_valid;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;
    t_cmd          q_cmd;
    logic [IW-1:0] q_idx;
    t_result       res;

    nrt_front #(
        .NODES (NODES),
        .IW    (IW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_slot       (i_slot),
        .i_node_id    (i_node_id),
        .i_version    (i_version),
        .i_context_id (i_context_id),
        .i_rssi       (i_rssi),
        .i_snr        (i_snr),
        .i_time_ms    (i_time_ms),
        .o_valid      (f_valid),
        .i_ready      (q_ready),
        .o_cmd        (f_cmd),
        .o_idx        (f_idx)
    );

    assign q_in = {f_cmd, f_idx};

    nrt_fifo #(
        .W     (QW),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_data  (q_in),
        .o_ready (q_ready),
        .i_rd    (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign {q_cmd, q_idx} = q_out;

    nrt_back #(
        .NODES (NODES),
        .IW    (IW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_cmd     (q_cmd),
        .i_idx     (q_idx),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_status          = res.status;
    assign o_seq_out         = res.seq;
    assign o_ctx_out         = res.ctx;
    assign o_heard_out       = res.heard;
    assign o_last_seen_out   = res.last_seen;
    assign o_frames_out      = res.frames;
    assign o_proto_out       = res.proto;
    assign o_bad_version_out = res.bad_ver;
    assign o_rssi_out        = res.rssi;
    assign o_snr_out         = res.snr;
    assign o_missed_out      = res.missed;

endmodule

// ----- rtl/core/nrt_front.sv -----
// ----------------------------------------------------------------------------
// nrt_front
// Accepts items, holds the slot ids and the loaded flag, matches the node id
// against every slot and hands a classified command with its slot index on.
// ----------------------------------------------------------------------------
module nrt_front #(
    parameter int NODES = 16,
    parameter int IW    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_opcode,
    input  logic [3:0]         i_slot,
    input  logic [7:0]         i_node_id,
    input  logic [7:0]         i_version,
    input  logic [15:0]        i_context_id,
    input  logic signed [15:0] i_rssi,
    input  logic signed [7:0]  i_snr,
    input  logic [31:0]        i_time_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output nrt_pkg::t_cmd      o_cmd,
    output logic [IW-1:0]      o_idx
);
    import nrt_pkg::*;

    logic [7:0]       r_ids [NODES];
    logic             r_loaded;
    logic             r_valid;
    t_cmd             r_cmd;
    logic [NODES-1:0] r_match;
    logic [NODES-1:0] n_match;
    logic [NODES-1:0] lowest;
    logic             accept;
    t_op              op_in;

    assign op_in  = t_op'(i_opcode);
    assign o_full = r_valid && !i_ready;
    assign accept = i_push && !o_full;

    always_comb begin
        for (int k = 0; k < NODES; k++) begin
            n_match[k] = r_loaded && (r_ids[k] == i_node_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_loaded <= 1'b0;
            for (int k = 0; k < NODES; k++) begin
                r_ids[k] <= 8'd0;
            end
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (accept && op_in == OP_LOAD) begin
                r_loaded <= 1'b1;
            end
            for (int k = 0; k < NODES; k++) begin
                if (accept && op_in == OP_SET_ID && {4'd0, i_slot} == 8'(k)) begin
                    r_ids[k] <= i_node_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_match       <= n_match;
            r_cmd.op      <= op_in;
            r_cmd.found   <= |n_match;
            r_cmd.version <= i_version;
            r_cmd.ctx     <= i_context_id;
            r_cmd.rssi    <= i_rssi;
            r_cmd.snr     <= i_snr;
            r_cmd.time_ms <= i_time_ms;
        end
    end

    // isolate the lowest matching slot, then encode it
    assign lowest = r_match & (~r_match + {{(NODES-1){1'b0}}, 1'b1});

    always_comb begin
        o_idx = '0;
        for (int k = 0; k < NODES; k++) begin
            if (lowest[k]) begin
                o_idx = o_idx | IW'(k);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

// ----- rtl/core/nrt_fifo.sv -----
// ----------------------------------------------------------------------------
// nrt_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module nrt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    input  logic         i_rd,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    import nrt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign wr_en   = i_wr && o_ready;
    assign rd_en   = i_rd && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/core/nrt_back.sv -----
// ----------------------------------------------------------------------------
// nrt_back
// Carries out commands: reads the node's link record, updates and writes it
// back where the command changes it, and holds the result in the output register.
// ----------------------------------------------------------------------------
module nrt_back #(
    parameter int NODES = 16,
    parameter int IW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  nrt_pkg::t_cmd    i_cmd,
    input  logic [IW-1:0]    i_idx,
    input  logic             i_pop,
    output logic             o_empty,
    output nrt_pkg::t_result o_res
);
    import nrt_pkg::*;

    t_link         r_mem [NODES];
    logic          r_vld [NODES];
    t_bstate       r_state;
    t_bstate       n_state;
    t_cmd          r_cmd;
    logic [IW-1:0] r_idx;
    t_link         r_rd_data;
    logic          r_rd_vld;
    logic          r_out_valid;
    t_result       r_res;

    t_link         cur;
    t_link         n_link;
    t_result       res;
    logic          wr;
    logic          clr;
    logic          out_ready;
    logic          fire;
    logic [15:0]   seq_inc;

    assign out_ready = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    n_state = BS_EXEC;
                end
            end
            BS_EXEC: begin
                if (out_ready) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        fire    = 1'b0;
        case (r_state)
            BS_IDLE: o_q_pop = i_q_valid;
            BS_EXEC: fire    = out_ready;
            default: ;
        endcase
    end

    assign cur     = r_rd_vld ? r_rd_data : '0;
    assign seq_inc = cur.seq + 16'd1;

    always_comb begin
        n_link = cur;
        res    = '0;
        wr     = 1'b0;
        clr    = 1'b0;
        case (r_cmd.op)
            OP_SET_ID: res.status = ST_OK;
            OP_LOAD:   clr = 1'b1;
            default: begin
                if (!r_cmd.found) begin
                    res.status = ST_UNREG;
                end else begin
                    case (r_cmd.op)
                        OP_OBSERVE: begin
                            wr               = 1'b1;
                            n_link.heard     = 1'b1;
                            n_link.last_seen = r_cmd.time_ms;
                            n_link.frames    = cur.frames + 32'd1;
                            n_link.proto     = r_cmd.version;
                            n_link.bad_ver   = 8'd0;
                            n_link.rssi      = r_cmd.rssi;
                            n_link.snr       = r_cmd.snr;
                            n_link.missed    = 16'd0;
                            if (r_cmd.ctx != 16'd0 && r_cmd.ctx != cur.ctx) begin
                                n_link.ctx = r_cmd.ctx;
                                n_link.seq = SEQ_START;
                                res.status = ST_NEW_CTX;
                            end
                        end
                        OP_TAKE_SEQ: begin
                            wr         = 1'b1;
                            res.seq    = cur.seq;
                            n_link.seq = (seq_inc == 16'd0) ? SEQ_START : seq_inc;
                        end
                        OP_ADOPT: begin
                            wr         = 1'b1;
                            n_link.ctx = r_cmd.ctx;
                            n_link.seq = SEQ_START;
                        end
                        OP_NOTE_VER: begin
                            wr             = 1'b1;
                            n_link.bad_ver = r_cmd.version;
                        end
                        OP_MISSED: begin
                            wr = 1'b1;
                            if (cur.missed != CNT_MAX) begin
                                n_link.missed = cur.missed + 16'd1;
                            end
                        end
                        OP_QUERY: begin
                            res.seq       = cur.seq;
                            res.ctx       = cur.ctx;
                            res.heard     = cur.heard;
                            res.last_seen = cur.last_seen;
                            res.frames    = cur.frames;
                            res.proto     = cur.proto;
                            res.bad_ver   = cur.bad_ver;
                            res.rssi      = cur.rssi;
                            res.snr       = cur.snr;
                            res.missed    = cur.missed;
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NODES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (fire && clr) begin
                for (int k = 0; k < NODES; k++) begin
                    r_vld[k] <= 1'b0;
                end
            end else if (fire && wr) begin
                r_vld[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd    <= i_cmd;
            r_idx    <= i_idx;
            r_rd_vld <= r_vld[i_idx];
        end
        if (fire) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && wr) begin
            r_mem[r_idx] <= n_link;
        end
        if (o_q_pop) begin
            r_rd_data <= r_mem[i_idx];
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_res;

endmodule

// ----- test/node_registry_table_tb.sv -----
// ----------------------------------------------------------------------------
// node_registry_table_tb
// Self-checking bench for the node registry table. Directed tests cover the
// unloaded table, slot ids with duplicates, load, field extremes, sequence
// and missed-poll counting. A random phase of mostly registered-node
// traffic follows. Each accepted item updates a local registry model whose
// results are compared field by field with what the block pops, while the
// sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module node_registry_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrt_pkg::*;

    localparam int NODES       = 16;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        t_op                op;
        logic [3:0]         slot;
        logic [7:0]         node_id;
        logic [7:0]         version;
        logic [15:0]        ctx;
        logic signed [15:0] rssi;
        logic signed [7:0]  snr;
        logic [31:0]        time_ms;
    } t_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [2:0]         i_opcode = '0;
    logic [3:0]         i_slot = '0;
    logic [7:0]         i_node_id = '0;
    logic [7:0]         i_version = '0;
    logic [15:0]        i_context_id = '0;
    logic signed [15:0] i_rssi = '0;
    logic signed [7:0]  i_snr = '0;
    logic [31:0]        i_time_ms = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         o_status;
    logic [15:0]        o_seq_out;
    logic [15:0]        o_ctx_out;
    logic               o_heard_out;
    logic [31:0]        o_last_seen_out;
    logic [31:0]        o_frames_out;
    logic [7:0]         o_proto_out;
    logic [7:0]         o_bad_version_out;
    logic signed [15:0] o_rssi_out;
    logic signed [7:0]  o_snr_out;
    logic [15:0]        o_missed_out;

    logic [7:0] reg_ids [NODES];
    logic       reg_loaded = 1'b0;
    t_link      reg_links [NODES];

    t_result reports_due [$];
    int      mismatches = 0;
    int      report_no = 0;
    int      burst_left = 0;
    bit      steady = 1'b0;
    int      rx_mode = 0;
    int      rx_left = 0;

    node_registry_table #(
        .NODES(NODES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_opcode         (i_opcode),
        .i_slot           (i_slot),
        .i_node_id        (i_node_id),
        .i_version        (i_version),
        .i_context_id     (i_context_id),
        .i_rssi           (i_rssi),
        .i_snr            (i_snr),
        .i_time_ms        (i_time_ms),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_seq_out        (o_seq_out),
        .o_ctx_out        (o_ctx_out),
        .o_heard_out      (o_heard_out),
        .o_last_seen_out  (o_last_seen_out),
        .o_frames_out     (o_frames_out),
        .o_proto_out      (o_proto_out),
        .o_bad_version_out(o_bad_version_out),
        .o_rssi_out       (o_rssi_out),
        .o_snr_out        (o_snr_out),
        .o_missed_out     (o_missed_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int find_node(logic [7:0] id);
        int hit;
        hit = -1;
        if (reg_loaded) begin
            for (int k = NODES - 1; k >= 0; k--) begin
                if (reg_ids[k] == id) begin
                    hit = k;
                end
            end
        end
        return hit;
    endfunction

    task automatic registry_apply(input t_event ev);
        t_result     res;
        t_link       lk;
        int          hit;
        logic [15:0] nxt;
        res = '0;
        res.status = ST_OK;
        case (ev.op)
            OP_SET_ID: begin
                reg_ids[ev.slot] = ev.node_id;
            end
            OP_LOAD: begin
                for (int k = 0; k < NODES; k++) begin
                    reg_links[k] = '0;
                end
                reg_loaded = 1'b1;
            end
            default: begin
                hit = find_node(ev.node_id);
                if (hit < 0) begin
                    res.status = ST_UNREG;
                end else begin
                    lk = reg_links[hit];
                    case (ev.op)
                        OP_OBSERVE: begin
                            lk.heard     = 1'b1;
                            lk.last_seen = ev.time_ms;
                            lk.frames    = lk.frames + 32'd1;
                            lk.proto     = ev.version;
                            lk.bad_ver   = '0;
                            lk.rssi      = ev.rssi;
                            lk.snr       = ev.snr;
                            lk.missed    = '0;
                            if (ev.ctx != '0 && ev.ctx != lk.ctx) begin
                                lk.ctx     = ev.ctx;
                                lk.seq     = SEQ_START;
                                res.status = ST_NEW_CTX;
                            end
                        end
                        OP_TAKE_SEQ: begin
                            res.seq = lk.seq;
                            nxt = lk.seq + 16'd1;
                            lk.seq = (nxt == '0) ? SEQ_START : nxt;
                        end
                        OP_ADOPT: begin
                            lk.ctx = ev.ctx;
                            lk.seq = SEQ_START;
                        end
                        OP_NOTE_VER: begin
                            lk.bad_ver = ev.version;
                        end
                        OP_MISSED: begin
                            if (lk.missed != CNT_MAX) begin
                                lk.missed = lk.missed + 16'd1;
                            end
                        end
                        default: begin
                            res.seq       = lk.seq;
                            res.ctx       = lk.ctx;
                            res.heard     = lk.heard;
                            res.last_seen = lk.last_seen;
                            res.frames    = lk.frames;
                            res.proto     = lk.proto;
                            res.bad_ver   = lk.bad_ver;
                            res.rssi      = lk.rssi;
                            res.snr       = lk.snr;
                            res.missed    = lk.missed;
                        end
                    endcase
                    reg_links[hit] = lk;
                end
            end
        endcase
        reports_due.push_back(res);
    endtask

    task automatic send_event(input t_op op, input logic [3:0] slot, input logic [7:0] node_id,
                              input logic [7:0] version, input logic [15:0] ctx,
                              input logic signed [15:0] rssi, input logic signed [7:0] snr,
                              input logic [31:0] tms);
        t_event ev;
        ev.op      = op;
        ev.slot    = slot;
        ev.node_id = node_id;
        ev.version = version;
        ev.ctx     = ctx;
        ev.rssi    = rssi;
        ev.snr     = snr;
        ev.time_ms = tms;
        if (!steady && burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        i_opcode     <= op;
        i_slot       <= slot;
        i_node_id    <= node_id;
        i_version    <= version;
        i_context_id <= ctx;
        i_rssi       <= rssi;
        i_snr        <= snr;
        i_time_ms    <= tms;
        push         <= 1'b1;
        do @(posedge i_clk); while (full);
        registry_apply(ev);
        if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic send_lookup(input t_op op, input logic [7:0] node_id);
        send_event(op, '0, node_id, '0, '0, '0, '0, '0);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] exp,
                                 input logic [31:0] act);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("report %0d: %s expected %h got %h", report_no, what, exp, act);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            flag_mismatch(what, exp, act);
        end
    endtask

    task automatic check_report();
        t_result exp;
        report_no++;
        if (reports_due.size() == 0) begin
            flag_mismatch("unexpected result, status", '0, o_status);
        end else begin
            exp = reports_due.pop_front();
            check_field("status", exp.status, o_status);
            check_field("seq_out", exp.seq, o_seq_out);
            check_field("ctx_out", exp.ctx, o_ctx_out);
            check_field("heard_out", exp.heard, o_heard_out);
            check_field("last_seen_out", exp.last_seen, o_last_seen_out);
            check_field("frames_out", exp.frames, o_frames_out);
            check_field("proto_out", exp.proto, o_proto_out);
            check_field("bad_version_out", exp.bad_ver, o_bad_version_out);
            check_field("rssi_out", exp.rssi, o_rssi_out);
            check_field("snr_out", exp.snr, o_snr_out);
            check_field("missed_out", exp.missed, o_missed_out);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_report();
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 128);
            end
            rx_left--;
            if (steady) begin
                pop <= 1'b1;
            end else begin
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom_range(0, 1));
                    2: pop <= (rx_left % 4) != 0;
                    default: pop <= (rx_left % 40) >= 30;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("node_registry_table: mismatch");
        $finish;
    end

    task automatic test_unloaded_lookups();
        send_lookup(OP_QUERY, 8'h00);
        send_event(OP_OBSERVE, '0, 8'h00, 8'h01, 16'h0001, 16'sd5, 8'sd3, 32'd10);
        send_lookup(OP_TAKE_SEQ, 8'h00);
    endtask

    task automatic test_slot_ids_and_load();
        send_lookup(OP_SET_ID, 8'h00);
        send_event(OP_SET_ID, 4'd0, 8'hA5, '0, '0, '0, '0, '0);
        send_event(OP_SET_ID, 4'd15, 8'hFF, '0, '0, '0, '0, '0);
        send_event(OP_SET_ID, 4'd3, 8'hA5, '0, '0, '0, '0, '0);
        send_lookup(OP_LOAD, 8'h00);
        send_lookup(OP_QUERY, 8'h5A);
        send_lookup(OP_QUERY, 8'h00);
    endtask

    task automatic test_observe_extremes();
        send_event(OP_OBSERVE, 4'hF, 8'hA5, 8'hFF, 16'hFFFF, 16'sh8000, 8'sh80, 32'hFFFF_FFFF);
        send_event(OP_OBSERVE, '0, 8'hA5, 8'h00, 16'hFFFF, 16'sh7FFF, 8'sh7F, 32'h0);
        send_event(OP_OBSERVE, '0, 8'hA5, 8'h55, 16'h0000, 16'sh0001, 8'sh01, 32'h1);
        send_lookup(OP_QUERY, 8'hA5);
    endtask

    task automatic test_sequence_and_context();
        send_lookup(OP_TAKE_SEQ, 8'hA5);
        send_lookup(OP_TAKE_SEQ, 8'hA5);
        send_event(OP_ADOPT, '0, 8'hFF, '0, 16'h0000, '0, '0, '0);
        send_lookup(OP_TAKE_SEQ, 8'hFF);
    endtask

    task automatic test_version_and_missed();
        send_event(OP_NOTE_VER, '0, 8'hFF, 8'h80, '0, '0, '0, '0);
        send_lookup(OP_MISSED, 8'hFF);
        send_lookup(OP_QUERY, 8'hFF);
        send_event(OP_OBSERVE, '0, 8'hFF, 8'h02, 16'h0001, 16'sh0F0F, 8'sh0F, 32'h1234_5678);
        send_lookup(OP_QUERY, 8'hFF);
    endtask

    task automatic test_reload();
        send_lookup(OP_LOAD, 8'h00);
        send_lookup(OP_QUERY, 8'hA5);
    endtask

    task automatic test_counter_limits();
        steady = 1'b1;
        send_event(OP_SET_ID, 4'd7, 8'h3C, '0, '0, '0, '0, '0);
        send_lookup(OP_LOAD, 8'h00);
        repeat (12) send_lookup(OP_MISSED, 8'h3C);
        send_lookup(OP_QUERY, 8'h3C);
        repeat (12) send_lookup(OP_TAKE_SEQ, 8'h3C);
        send_lookup(OP_QUERY, 8'h3C);
        steady = 1'b0;
    endtask

    function automatic logic [7:0] pick_node();
        if ($urandom_range(0, 9) < 8) begin
            return reg_ids[$urandom_range(0, NODES - 1)];
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_slot_id();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {4'hA, 4'($urandom)};
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_random_traffic();
        int          r;
        int          hit;
        t_op         op;
        logic [7:0]  id;
        logic [15:0] ctx;
        for (int n = 0; n < 950; n++) begin
            r   = $urandom_range(0, 99);
            id  = pick_node();
            ctx = 16'($urandom);
            if (r < 2) begin
                op = OP_LOAD;
            end else if (r < 10) begin
                op = OP_SET_ID;
                id = pick_slot_id();
            end else if (r < 35) begin
                op  = OP_OBSERVE;
                hit = find_node(id);
                case ($urandom_range(0, 3))
                    0: ctx = '0;
                    1: if (hit >= 0) ctx = reg_links[hit].ctx;
                    default: ;
                endcase
            end else if (r < 50) begin
                op = OP_TAKE_SEQ;
            end else if (r < 58) begin
                op = OP_ADOPT;
                if ($urandom_range(0, 3) == 0) ctx = '0;
            end else if (r < 66) begin
                op = OP_NOTE_VER;
            end else if (r < 76) begin
                op = OP_MISSED;
            end else begin
                op = OP_QUERY;
            end
            send_event(op, 4'($urandom), id, 8'($urandom), ctx, 16'($urandom),
                       8'($urandom), $urandom);
        end
    endtask

    initial begin
        for (int k = 0; k < NODES; k++) begin
            reg_ids[k]   = '0;
            reg_links[k] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unloaded_lookups();
        test_slot_ids_and_load();
        test_observe_extremes();
        test_sequence_and_context();
        test_version_and_missed();
        test_reload();
        test_counter_limits();
        test_random_traffic();
        push <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("node_registry_table: match");
        end else begin
            $display("node_registry_table: mismatch");
        end
        $finish;
    end

endmodule
